### src/sspwm_pkg.sv
// Package for the staggered slow PWM block: widths, codes, constants and the
// sequencer state type. No dependencies; every other file imports it.
package sspwm_pkg;

    localparam int PERIOD_W = 24;
    localparam int LEVEL_W  = 14;
    localparam int CH_W     = 3;
    localparam int MAX_CH   = 8;
    localparam int QLV_W    = 11;   // period / 10000 never exceeds 1677

    // Division by a constant is done as a multiplication by a rounded-up
    // reciprocal followed by a right shift. The channel divisor is at most 8
    // on a 24-bit dividend; the level divisor 10000 is split into a shift by
    // four and a division by 625 on the remaining 20 bits.
    localparam int RECIP_W  = 28;
    localparam int CH_SHIFT = 27;
    localparam int LV_SHIFT = 30;
    localparam logic [RECIP_W-1:0] LV_RECIP = 28'd1717987;   // ceil(2^30 / 625)

    localparam logic [LEVEL_W-1:0]  FULL_LEVEL   = 14'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd900000;

    // Configuration register indexes.
    localparam logic REG_PERIOD   = 1'b0;
    localparam logic REG_POLARITY = 1'b1;

    // Input item kinds carried on tuser.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV_CH = 6'b000010,
        ST_DIV_LV = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_EVAL   = 6'b010000,
        ST_OUT    = 6'b100000
    } seq_state_t;

endpackage

### src/sspwm_div.sv
// Shared reciprocal multiply unit for both period divisions by a constant;
// it registers the quotient and pulses done. Depends on sspwm_pkg.
module sspwm_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             lv_sel,
    input  logic [sspwm_pkg::PERIOD_W-1:0]   dividend,
    input  logic [sspwm_pkg::RECIP_W-1:0]    ch_recip,
    output logic [sspwm_pkg::PERIOD_W-1:0]   quotient,
    output logic                             done
);
    import sspwm_pkg::*;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        sel_reg, sel_next;
    logic [PERIOD_W-1:0]         opa_reg, opa_next;
    logic [RECIP_W-1:0]          opb_reg, opb_next;
    logic [PERIOD_W-1:0]         quo_reg, quo_next;
    logic [PERIOD_W+RECIP_W-1:0] product;

    assign product = opa_reg * opb_reg;

    always_comb
    begin
        busy_next = 1'b0;
        done_next = 1'b0;
        sel_next  = sel_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // The level division drops the low four bits first (10000 = 16 * 625).
            busy_next = 1'b1;
            sel_next  = lv_sel;
            opa_next  = lv_sel ? {4'd0, dividend[PERIOD_W-1:4]} : dividend;
            opb_next  = lv_sel ? LV_RECIP : ch_recip;
        end
        else if (busy_reg)
        begin
            quo_next  = sel_reg ? PERIOD_W'(product >> LV_SHIFT)
                                : PERIOD_W'(product >> CH_SHIFT);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### src/sspwm_win.sv
// Shared window unit: registers the window length, then decides whether the
// current time falls strictly inside the wrapped window. Depends on sspwm_pkg.
module sspwm_win (
    input  logic                           clk,
    input  logic                           load,
    input  logic [sspwm_pkg::QLV_W-1:0]    qlv,
    input  logic [sspwm_pkg::LEVEL_W-1:0]  level,
    input  logic                           enable,
    input  logic [sspwm_pkg::PERIOD_W-1:0] start_pos,
    input  logic [sspwm_pkg::PERIOD_W-1:0] period,
    input  logic [sspwm_pkg::PERIOD_W-1:0] t,
    output logic                           on
);
    import sspwm_pkg::*;

    logic [QLV_W+LEVEL_W-1:0] product;
    logic [PERIOD_W-1:0]      dur_reg;
    logic [PERIOD_W:0]        sum;
    logic [PERIOD_W:0]        wrapped;
    logic [PERIOD_W-1:0]      stop;
    logic                     in_win;

    // The product never exceeds the period, so it fits the period width.
    assign product = qlv * level;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dur_reg <= product[PERIOD_W-1:0];
        end
    end

    // Start and length are each at most one period, so one subtraction wraps.
    assign sum     = {1'b0, start_pos} + {1'b0, dur_reg};
    assign wrapped = sum - {1'b0, period};
    assign stop    = (sum >= {1'b0, period}) ? wrapped[PERIOD_W-1:0] : sum[PERIOD_W-1:0];

    always_comb
    begin
        if (start_pos < stop)
        begin
            in_win = (t > start_pos) && (t < stop);
        end
        else
        begin
            in_win = (t > start_pos) || (t < stop);
        end
    end

    always_comb
    begin
        if (!enable || level == '0)
        begin
            on = 1'b0;
        end
        else if (level >= FULL_LEVEL)
        begin
            on = 1'b1;
        end
        else
        begin
            on = in_win;
        end
    end

endmodule

### src/staggered_slow_pwm_channels.sv
// Top level of the staggered slow PWM block: channel request store, sequencer
// and output register. Depends on sspwm_pkg, sspwm_div and sspwm_win.
//
// A set transfer is taken while idle and produces no result. A tick is
// accepted, then one shared window unit serves each channel in turn (length
// multiply, then window compare), and the result register is loaded last.
// After reset and after every write of period_ms, the next tick first
// computes period/CHANNELS and period/10000 on a shared reciprocal multiply
// unit; later ticks skip this step. The input is not ready while a tick is
// in work; a finished result waits in the output register, and the block
// accepts new transfers as soon as it has loaded it.
module staggered_slow_pwm_channels #(
    parameter int CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // channel[2:0], enable[3], level[17:4], zero fill
    input  logic        s_tuser,   // command: 0 tick, 1 set request
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // drive[7:0], feedback_mask[15:8], save_request[16]
);
    import sspwm_pkg::*;

    localparam logic [CH_W-1:0]    LAST_CH  = CH_W'(CHANNELS - 1);
    localparam logic [MAX_CH-1:0]  ALL_MASK = MAX_CH'((1 << CHANNELS) - 1);
    // Rounded-up reciprocal of the channel count for the start spacing.
    localparam logic [RECIP_W-1:0] CH_RECIP =
        RECIP_W'(((1 << CH_SHIFT) + CHANNELS - 1) / CHANNELS);

    // Configuration registers.
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                active_high_reg, active_high_next;
    logic                div_ok_reg, div_ok_next;

    // Channel requests and last reported copies.
    logic                req_en_reg   [MAX_CH];
    logic                req_en_next  [MAX_CH];
    logic [LEVEL_W-1:0]  req_lvl_reg  [MAX_CH];
    logic [LEVEL_W-1:0]  req_lvl_next [MAX_CH];
    logic                rep_en_reg   [MAX_CH];
    logic                rep_en_next  [MAX_CH];
    logic [LEVEL_W-1:0]  rep_lvl_reg  [MAX_CH];
    logic [LEVEL_W-1:0]  rep_lvl_next [MAX_CH];

    // Period state.
    logic [PERIOD_W-1:0] time_reg, time_next;
    logic                first_tick_reg, first_tick_next;
    logic                css_reg, css_next;

    // Sequencer and per-tick work registers.
    seq_state_t          state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [PERIOD_W-1:0] t_reg, t_next;
    logic                ps_reg, ps_next;
    logic [PERIOD_W-1:0] start_reg, start_next;
    logic [PERIOD_W-1:0] qch_reg, qch_next;
    logic [QLV_W-1:0]    qlv_reg, qlv_next;
    logic [MAX_CH-1:0]   drv_reg, drv_next;
    logic [MAX_CH-1:0]   fb_reg, fb_next;
    logic                chg_reg, chg_next;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic [MAX_CH-1:0]   o_drv_reg, o_drv_next;
    logic [MAX_CH-1:0]   o_fb_reg, o_fb_next;
    logic                o_save_reg, o_save_next;

    logic [PERIOD_W-1:0] p_eff;
    logic                in_xfer;
    logic [CH_W-1:0]     in_ch;
    logic                in_en;
    logic [LEVEL_W-1:0]  in_lvl;
    logic                div_start;
    logic                div_lv_sel;
    logic [PERIOD_W-1:0] quotient;
    logic                div_done;
    logic                win_load;
    logic                win_on;
    logic                ch_changed;
    logic                css_any;
    logic [PERIOD_W:0]   t_inc;

    // A zero period behaves as a period of one tick.
    assign p_eff   = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign in_xfer = s_tvalid && s_tready;
    assign in_ch   = s_tdata[2:0];
    assign in_en   = s_tdata[3];
    assign in_lvl  = s_tdata[17:4];
    // The level division is started from the channel division step.
    assign div_lv_sel = (state_reg == ST_DIV_CH);
    assign win_load = (state_reg == ST_MUL);

    sspwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .lv_sel   (div_lv_sel),
        .dividend (p_eff),
        .ch_recip (CH_RECIP),
        .quotient (quotient),
        .done     (div_done)
    );

    sspwm_win u_win (
        .clk       (clk),
        .load      (win_load),
        .qlv       (qlv_reg),
        .level     (req_lvl_reg[ch_reg]),
        .enable    (req_en_reg[ch_reg]),
        .start_pos (start_reg),
        .period    (p_eff),
        .t         (t_reg),
        .on        (win_on)
    );

    assign ch_changed = (req_en_reg[ch_reg] != rep_en_reg[ch_reg])
                     || (req_lvl_reg[ch_reg] != rep_lvl_reg[ch_reg]);
    assign css_any    = css_reg || chg_reg;
    assign t_inc      = {1'b0, t_reg} + (PERIOD_W+1)'(1);

    always_comb
    begin
        period_next      = period_reg;
        active_high_next = active_high_reg;
        div_ok_next      = div_ok_reg;
        req_en_next      = req_en_reg;
        req_lvl_next     = req_lvl_reg;
        rep_en_next      = rep_en_reg;
        rep_lvl_next     = rep_lvl_reg;
        time_next        = time_reg;
        first_tick_next  = first_tick_reg;
        css_next         = css_reg;
        state_next       = state_reg;
        ch_next          = ch_reg;
        t_next           = t_reg;
        ps_next          = ps_reg;
        start_next       = start_reg;
        qch_next         = qch_reg;
        qlv_next         = qlv_reg;
        drv_next         = drv_reg;
        fb_next          = fb_reg;
        chg_next         = chg_reg;
        m_valid_next     = m_valid_reg;
        o_drv_next       = o_drv_reg;
        o_fb_next        = o_fb_reg;
        o_save_next      = o_save_reg;
        div_start        = 1'b0;
        s_tready         = (state_reg == ST_IDLE);

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // Configuration must be written only while no tick is in work; not enforced.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PERIOD:
                begin
                    period_next = cfg_data;
                    div_ok_next = 1'b0;
                end
                REG_POLARITY:
                begin
                    active_high_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && s_tuser == CMD_SET)
                begin
                    if (32'(in_ch) < CHANNELS)
                    begin
                        req_en_next[in_ch]  = in_en;
                        req_lvl_next[in_ch] = (in_lvl > FULL_LEVEL) ? FULL_LEVEL : in_lvl;
                    end
                end
                else if (in_xfer)
                begin
                    t_next          = (time_reg >= p_eff) ? '0 : time_reg;
                    ps_next         = (time_reg >= p_eff) || (time_reg == '0)
                                   || first_tick_reg;
                    first_tick_next = 1'b0;
                    ch_next         = '0;
                    start_next      = '0;
                    drv_next        = '0;
                    fb_next         = '0;
                    chg_next        = 1'b0;
                    if (div_ok_reg)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_CH;
                    end
                end
            end
            ST_DIV_CH:
            begin
                if (div_done)
                begin
                    qch_next   = quotient;
                    div_start  = 1'b1;
                    state_next = ST_DIV_LV;
                end
            end
            ST_DIV_LV:
            begin
                if (div_done)
                begin
                    qlv_next    = quotient[QLV_W-1:0];
                    div_ok_next = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (ch_changed)
                begin
                    rep_en_next[ch_reg]  = req_en_reg[ch_reg];
                    rep_lvl_next[ch_reg] = req_lvl_reg[ch_reg];
                    chg_next             = 1'b1;
                end
                drv_next[ch_reg] = (active_high_reg == win_on);
                fb_next[ch_reg]  = ch_changed || ps_reg;
                start_next       = start_reg + qch_reg;
                if (ch_reg == LAST_CH)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                // Wait until the result register is free or being emptied.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    o_drv_next   = drv_reg & ALL_MASK;
                    o_fb_next    = fb_reg & ALL_MASK;
                    o_save_next  = css_any && ps_reg;
                    css_next     = css_any && !ps_reg;
                    time_next    = (t_inc >= {1'b0, p_eff}) ? '0 : t_inc[PERIOD_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= PERIOD_RESET;
            active_high_reg <= 1'b0;
            div_ok_reg      <= 1'b0;
            for (int i = 0; i < MAX_CH; i++)
            begin
                req_en_reg[i]  <= 1'b0;
                req_lvl_reg[i] <= '0;
                rep_en_reg[i]  <= 1'b1;
                rep_lvl_reg[i] <= '0;
            end
            time_reg       <= '0;
            first_tick_reg <= 1'b1;
            css_reg        <= 1'b0;
            state_reg      <= ST_IDLE;
            ch_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            period_reg      <= period_next;
            active_high_reg <= active_high_next;
            div_ok_reg      <= div_ok_next;
            req_en_reg      <= req_en_next;
            req_lvl_reg     <= req_lvl_next;
            rep_en_reg      <= rep_en_next;
            rep_lvl_reg     <= rep_lvl_next;
            time_reg        <= time_next;
            first_tick_reg  <= first_tick_next;
            css_reg         <= css_next;
            state_reg       <= state_next;
            ch_reg          <= ch_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        ps_reg     <= ps_next;
        start_reg  <= start_next;
        qch_reg    <= qch_next;
        qlv_reg    <= qlv_next;
        drv_reg    <= drv_next;
        fb_reg     <= fb_next;
        chg_reg    <= chg_next;
        o_drv_reg  <= o_drv_next;
        o_fb_reg   <= o_fb_next;
        o_save_reg <= o_save_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_save_reg, o_fb_reg, o_drv_reg};

`ifndef ASSERT_OFF
    // A save request only comes with a period start, which reports every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> ((m_tdata[15:8] & ALL_MASK) == ALL_MASK))
        else $error("save request without a full feedback mask");

    // The window unit is never used before both quotients are ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_EVAL) |-> div_ok_reg)
        else $error("channel evaluation with stale quotients");

    // The channel sweep never leaves the configured channel range.
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= LAST_CH)
        else $error("channel counter out of range");

    // A new result is loaded only from the output step of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");
`endif

endmodule

### bench/staggered_slow_pwm_channels_test.sv
// Self-checking testbench for staggered_slow_pwm_channels: directed and random
// set and tick transfers, predicted in a small checker class.
// Depends on sspwm_pkg and the block's top level only.
module staggered_slow_pwm_channels_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sspwm_pkg::*;

    localparam int NUM_CH = MAX_CH;
    // A tick runs through every channel, after a period write also through the
    // divisions, so this many quiet cycles cover any work still in flight.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PRESSURE_HOLD = 400;

    // One tick result as it appears on m_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic       save_request;
        logic [7:0] feedback_mask;
        logic [7:0] drive;
    } tick_result_t;

    // Predicts the result of every tick from its own copy of the channel
    // requests, the reported copies, the period counter and the registers,
    // and compares each result leaving the block with the oldest prediction.
    class staggered_pwm_checker;
        logic [PERIOD_W-1:0] period_reg;
        logic                polarity_reg;
        logic                req_enable [NUM_CH];
        logic [LEVEL_W-1:0]  req_level  [NUM_CH];
        logic                rep_enable [NUM_CH];
        logic [LEVEL_W-1:0]  rep_level  [NUM_CH];
        logic [PERIOD_W-1:0] ms_in_period;
        logic                period_opening;
        logic                unsaved_change;
        tick_result_t        expected_ticks[$];
        int                  results_seen;
        int                  errors;

        function new();
            period_reg = PERIOD_RESET;
            polarity_reg = 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                req_enable[i] = 1'b0;
                req_level[i] = '0;
                rep_enable[i] = 1'b1;
                rep_level[i] = '0;
            end
            ms_in_period = '0;
            period_opening = 1'b1;
            unsaved_change = 1'b0;
            results_seen = 0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH: %s", msg);
        endtask

        function int pending();
            return expected_ticks.size();
        endfunction

        function void write_reg(logic idx, logic [PERIOD_W-1:0] data);
            if (idx == REG_PERIOD)
                period_reg = data;
            else
                polarity_reg = data[0];
        endfunction

        // The on-window of a channel, both bounds exclusive, may wrap past
        // the end of the period.
        function bit in_window(longint unsigned t, longint unsigned p,
                               longint unsigned idx, longint unsigned lvl);
            longint unsigned first_ms;
            longint unsigned stop_ms;
            first_ms = (p / NUM_CH) * idx;
            stop_ms = (first_ms + (p / 64'(FULL_LEVEL)) * lvl) % p;
            if (first_ms < stop_ms)
                return t > first_ms && t < stop_ms;
            return t > first_ms || t < stop_ms;
        endfunction

        function void note_transfer(logic cmd, logic [CH_W-1:0] ch, logic en,
                                    logic [LEVEL_W-1:0] lvl);
            longint unsigned p;
            longint unsigned t;
            bit              opening;
            bit              changed;
            bit              on;
            tick_result_t    res;
            if (cmd == CMD_SET)
            begin
                // Levels above full scale are stored as full scale.
                req_enable[ch] = en;
                req_level[ch] = (lvl > FULL_LEVEL) ? FULL_LEVEL : lvl;
                return;
            end
            p = (period_reg == '0) ? 64'd1 : 64'(period_reg);
            t = 64'(ms_in_period);
            if (t >= p)
                t = 0;
            opening = (t == 0) || period_opening;
            period_opening = 1'b0;
            res = '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                changed = 1'b0;
                on = 1'b0;
                if (req_enable[i] != rep_enable[i] || req_level[i] != rep_level[i])
                begin
                    rep_enable[i] = req_enable[i];
                    rep_level[i] = req_level[i];
                    changed = 1'b1;
                    unsaved_change = 1'b1;
                end
                if (req_enable[i])
                begin
                    if (req_level[i] == 0)
                        on = 1'b0;
                    else if (req_level[i] >= FULL_LEVEL)
                        on = 1'b1;
                    else
                        on = in_window(t, p, 64'(i), 64'(req_level[i]));
                end
                res.drive[i] = (polarity_reg == on);
                res.feedback_mask[i] = changed || opening;
            end
            if (unsaved_change && opening)
            begin
                unsaved_change = 1'b0;
                res.save_request = 1'b1;
            end
            t = t + 1;
            if (t >= p)
                t = 0;
            ms_in_period = t[PERIOD_W-1:0];
            expected_ticks.push_back(res);
        endfunction

        task check_tick_result(logic [23:0] data);
            tick_result_t got;
            tick_result_t want;
            got = data[16:0];
            results_seen++;
            if (expected_ticks.size() == 0)
            begin
                report($sformatf("result %0d arrived with no tick pending (data %06h)",
                                 results_seen, data));
                return;
            end
            want = expected_ticks.pop_front();
            if (got.drive !== want.drive)
                report($sformatf("result %0d drive %02h, expected %02h",
                                 results_seen, got.drive, want.drive));
            if (got.feedback_mask !== want.feedback_mask)
                report($sformatf("result %0d feedback_mask %02h, expected %02h",
                                 results_seen, got.feedback_mask, want.feedback_mask));
            if (got.save_request !== want.save_request)
                report($sformatf("result %0d save_request %0b, expected %0b",
                                 results_seen, got.save_request, want.save_request));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // channel[2:0], enable[3], level[17:4], zero fill
    logic        s_tuser;   // command: 0 tick, 1 set request
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // drive[7:0], feedback_mask[15:8], save_request[16]

    staggered_pwm_checker checker_h;

    // Idle and stall rates in percent, and the long receiver hold-off flag.
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;
    int elapsed_cycles;

    staggered_slow_pwm_channels DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog ends a run that hangs, for instance when a tick result
    // never comes back.
    always @(posedge clk)
    begin
        elapsed_cycles++;
        if (elapsed_cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver decides its ready at each falling edge: held off while a
    // pressure stretch is running, otherwise stalling at the current rate.
    always @(negedge clk)
    begin
        if (recv_hold)
            m_tready <= 1'b0;
        else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Every result transfer is checked at the rising edge where it happens.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            checker_h.check_tick_result(m_tdata);
    end

    // Offers one input item and returns at the rising edge that takes it.
    // Idle cycles before the item come at the sender's current rate; valid
    // stays high from one item to the next when no idle cycle falls between.
    task automatic send_transfer(logic cmd, logic [CH_W-1:0] ch, logic en,
                                 logic [LEVEL_W-1:0] lvl);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'b0, lvl, en, ch};
        do
            @(posedge clk);
        while (!s_tready);
        checker_h.note_transfer(cmd, ch, en, lvl);
    endtask

    // Drops valid and waits until every predicted result has come back, then
    // lets the block finish anything still in work (a set produces no result).
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (checker_h.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only written while the block is idle.
    task automatic write_register(logic idx, logic [23:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        checker_h.write_reg(idx, data);
    endtask

    // Keeps the receiver from taking results for a long stretch so that the
    // output register fills and the block stops taking input transfers.
    task automatic hold_receiver(int cycles);
        @(posedge clk);
        recv_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    // Random mix of set requests and ticks. Levels lean on the edges: zero,
    // full scale, values above full scale that get clamped, and short windows
    // whose edges are easy to hit near the start of a period.
    task automatic random_items(int count);
        int                 pick;
        logic [LEVEL_W-1:0] lvl;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 35)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0:       lvl = '0;
                    1:       lvl = FULL_LEVEL;
                    2:       lvl = LEVEL_W'($urandom_range(16383, 10001));
                    3:       lvl = LEVEL_W'($urandom_range(20, 1));
                    default: lvl = LEVEL_W'($urandom_range(9999, 1));
                endcase
                send_transfer(CMD_SET, CH_W'($urandom_range(NUM_CH - 1)),
                              ($urandom_range(3) != 0), lvl);
            end
            else
            begin
                // The other fields of a tick are ignored, so they carry noise.
                send_transfer(CMD_TICK, CH_W'($urandom), 1'($urandom),
                              LEVEL_W'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [23:0] period_value;
        checker_h = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_PERIOD;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = CMD_TICK;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        elapsed_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first tick opens a period, and every reported enable differs
        // from its request, so all feedback bits and the save request rise.
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        // Level zero, full level, a clamped level, a disabled channel, the
        // shortest window and windows that wrap past the end of the period.
        send_transfer(CMD_SET, 3'd0, 1'b1, '0);
        send_transfer(CMD_SET, 3'd1, 1'b1, FULL_LEVEL);
        send_transfer(CMD_SET, 3'd2, 1'b1, 14'h3FFF);
        send_transfer(CMD_SET, 3'd3, 1'b0, 14'd5000);
        send_transfer(CMD_SET, 3'd4, 1'b1, 14'd9999);
        send_transfer(CMD_SET, 3'd5, 1'b1, 14'd5000);
        send_transfer(CMD_SET, 3'd6, 1'b1, 14'd1234);
        send_transfer(CMD_SET, 3'd7, 1'b1, 14'd1);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        wait_idle();

        // A zero period acts as one, so every tick opens a period; a change
        // on such a tick raises the save request on that same tick.
        write_register(REG_PERIOD, '0);
        write_register(REG_POLARITY, 24'd1);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        send_transfer(CMD_SET, 3'd5, 1'b1, 14'd3000);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        wait_idle();

        write_register(REG_PERIOD, 24'hFFFFFF);
        write_register(REG_POLARITY, 24'd0);
        send_transfer(CMD_SET, 3'd0, 1'b1, FULL_LEVEL);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        send_transfer(CMD_TICK, '0, 1'b0, '0);
        wait_idle();

        write_register(REG_PERIOD, 24'd16);
        write_register(REG_POLARITY, 24'd1);
        repeat (4) send_transfer(CMD_TICK, '0, 1'b0, '0);

        // Random phases rotate through the idling modes. Most periods are
        // short so that periods open often and windows are crossed many
        // times; the register extremes come first.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
            endcase
            case (phase)
                0:       period_value = 24'd10000;
                1:       period_value = 24'hFFFFFF;
                2:       period_value = 24'd1;
                3:       period_value = '0;
                default:
                begin
                    case ($urandom_range(9))
                        6, 7:    period_value = 24'($urandom_range(30000, 10000));
                        8:       period_value = 24'($urandom);
                        9:       period_value = PERIOD_RESET;
                        default: period_value = 24'($urandom_range(64, 2));
                    endcase
                end
            endcase
            write_register(REG_PERIOD, period_value);
            if (phase % 3 != 2)
                write_register(REG_POLARITY, 24'($urandom_range(1)));
            if (phase == 4)
            begin
                fork
                    hold_receiver(PRESSURE_HOLD);
                    random_items(ITEMS_PER_PHASE);
                join
            end
            else
            begin
                random_items(ITEMS_PER_PHASE);
            end
        end

        wait_idle();
        if (checker_h.pending() != 0)
            checker_h.report($sformatf("%0d tick results never arrived",
                                       checker_h.pending()));
        if (checker_h.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
